@@ rtl/core/pdi_pkg.sv @@
package pdi_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned RootWidth    = 16;
  localparam int unsigned CoordWidth   = 15;
  localparam int unsigned SquareWidth  = 2 * CoordWidth;
  localparam int unsigned NumSteps     = RootWidth;
  localparam int unsigned StepWidth    = $clog2(NumSteps);

  typedef enum logic {
    CMD_DISTANCE = 1'b0,
    CMD_ROOT     = 1'b1
  } command_t;

  // data carried from one root cell to the next
  typedef struct packed {
    logic                    valid;
    logic [OperandWidth-1:0] rem;
    logic [OperandWidth-1:0] acc;
  } cell_data_t;

  // probe bit for a given digit step, starting at 1 << 30
  function automatic logic [OperandWidth-1:0] probe_bit(input logic [StepWidth-1:0] step);
    logic [StepWidth-1:0] shamt;
    shamt = StepWidth'(NumSteps - 1) - step;
    return {{(OperandWidth-1){1'b0}}, 1'b1} << {shamt, 1'b0};
  endfunction

endpackage

@@ rtl/core/pdi_prep.sv @@
module pdi_prep (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic                                in_valid,
  input  pdi_pkg::command_t                   command,
  input  logic [pdi_pkg::OperandWidth-1:0]    radicand,
  input  logic [pdi_pkg::CoordWidth-1:0]      first_x,
  input  logic [pdi_pkg::CoordWidth-1:0]      first_y,
  input  logic [pdi_pkg::CoordWidth-1:0]      second_x,
  input  logic [pdi_pkg::CoordWidth-1:0]      second_y,
  output pdi_pkg::cell_data_t                 d_out
);

  logic                                valid_r;
  pdi_pkg::command_t                   cmd_r;
  logic [pdi_pkg::OperandWidth-1:0]    radicand_r;
  logic [pdi_pkg::SquareWidth-1:0]     sq_x_r;
  logic [pdi_pkg::SquareWidth-1:0]     sq_y_r;
  logic [pdi_pkg::CoordWidth-1:0]      dx;
  logic [pdi_pkg::CoordWidth-1:0]      dy;
  logic [pdi_pkg::SquareWidth-1:0]     sq_x_nxt;
  logic [pdi_pkg::SquareWidth-1:0]     sq_y_nxt;
  logic [pdi_pkg::SquareWidth:0]       sum;
  pdi_pkg::cell_data_t                 d_out_r;
  pdi_pkg::cell_data_t                 d_out_nxt;

  // absolute differences and squares
  always_comb begin
    dx       = (second_x >= first_x) ? (second_x - first_x) : (first_x - second_x);
    dy       = (second_y >= first_y) ? (second_y - first_y) : (first_y - second_y);
    sq_x_nxt = pdi_pkg::SquareWidth'(dx) * pdi_pkg::SquareWidth'(dx);
    sq_y_nxt = pdi_pkg::SquareWidth'(dy) * pdi_pkg::SquareWidth'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
    if (advance) begin
      cmd_r      <= command;
      radicand_r <= radicand;
      sq_x_r     <= sq_x_nxt;
      sq_y_r     <= sq_y_nxt;
    end
  end

  // squared sum or direct operand
  always_comb begin
    sum             = {1'b0, sq_x_r} + {1'b0, sq_y_r};
    d_out_nxt.valid = valid_r;
    d_out_nxt.acc   = '0;
    case (cmd_r)
      pdi_pkg::CMD_DISTANCE: d_out_nxt.rem = pdi_pkg::OperandWidth'(sum);
      pdi_pkg::CMD_ROOT:     d_out_nxt.rem = radicand_r;
      default:               d_out_nxt.rem = radicand_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out_r <= '0;
    end else if (advance) begin
      d_out_r <= d_out_nxt;
    end
  end

  assign d_out = d_out_r;

endmodule

@@ rtl/core/pdi_cell.sv @@
module pdi_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  logic [pdi_pkg::OperandWidth-1:0] probe,
  input  pdi_pkg::cell_data_t              d_in,
  output pdi_pkg::cell_data_t              d_out
);

  logic [pdi_pkg::OperandWidth-1:0] trial;
  logic                             take;
  pdi_pkg::cell_data_t              d_out_r;
  pdi_pkg::cell_data_t              d_out_nxt;

  // one restoring bit-pair digit
  always_comb begin
    trial           = d_in.acc + probe;
    take            = (d_in.rem >= trial);
    d_out_nxt.valid = d_in.valid;
    d_out_nxt.rem   = take ? (d_in.rem - trial) : d_in.rem;
    d_out_nxt.acc   = take ? ((d_in.acc >> 1) + probe) : (d_in.acc >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out_r <= '0;
    end else if (advance) begin
      d_out_r <= d_out_nxt;
    end
  end

  assign d_out = d_out_r;

endmodule

@@ rtl/core/point_distance_isqrt_core.sv @@
// Floor square root engine with a point distance front end. Command 0 takes two
// points with 15-bit unsigned coordinates and returns floor(sqrt(dx*dx + dy*dy));
// command 1 returns floor(sqrt(radicand)) for a 32-bit unsigned radicand, and
// zero gives zero. Every accepted item produces exactly one 16-bit result, in
// order. The datapath is two front-end registers (squares, then the squared sum
// or the radicand) followed by a row of 16 identical root cells, each resolving
// one root digit from the top bit pair down and passing remainder and partial
// root to the next cell. out_valid for an item rises once it has passed the
// first front-end register, which captures at the edge that takes it, then the
// second front-end register and the 16 digit cells in turn. The whole row
// shifts together, so a new item can be taken in any cycle in which the result
// port is not stalled; while out_valid is high and out_ready is low everything
// holds and in_ready is low.
module point_distance_isqrt_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic [pdi_pkg::OperandWidth-1:0] in_radicand,
  input  logic [pdi_pkg::CoordWidth-1:0]   in_first_x,
  input  logic [pdi_pkg::CoordWidth-1:0]   in_first_y,
  input  logic [pdi_pkg::CoordWidth-1:0]   in_second_x,
  input  logic [pdi_pkg::CoordWidth-1:0]   in_second_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pdi_pkg::RootWidth-1:0]    out_root_value
);

  // global shift enable for the whole row
  logic                advance;
  pdi_pkg::command_t   command;
  // chain[0] comes from the front end, chain[NumSteps] is the finished root
  pdi_pkg::cell_data_t chain [0:pdi_pkg::NumSteps];

  assign command = pdi_pkg::command_t'(in_command);

  // the last cell doubles as the output register
  assign out_valid = chain[pdi_pkg::NumSteps].valid;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;

  // front end: absolute differences, squares, then squared sum or radicand
  pdi_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_valid (in_valid),
    .command  (command),
    .radicand (in_radicand),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .d_out    (chain[0])
  );

  // row of digit cells, probe bit moving down two places per cell
  for (genvar i = 0; i < pdi_pkg::NumSteps; i++) begin : g_cell
    pdi_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .probe   (pdi_pkg::probe_bit(pdi_pkg::StepWidth'(i))),
      .d_in    (chain[i]),
      .d_out   (chain[i+1])
    );
  end

  // root is at most 16 bits once all digits are done
  assign out_root_value = chain[pdi_pkg::NumSteps].acc[pdi_pkg::RootWidth-1:0];

  // reset empties the row
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled row keeps its entry stage untouched
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(chain[0]))
    else $error("entry stage changed while stalled");

  // floor root property: leftover never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, chain[pdi_pkg::NumSteps].rem}
                   <= {chain[pdi_pkg::NumSteps].acc, 1'b0}))
    else $error("root remainder out of range");

  // the finished root fits the result field
  a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (chain[pdi_pkg::NumSteps].acc[pdi_pkg::OperandWidth-1:pdi_pkg::RootWidth]
                   == '0))
    else $error("root wider than result field");

endmodule

@@ verif/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one request as it sits on the input ports
  typedef struct packed {
    pdi_pkg::command_t                command;
    logic [pdi_pkg::OperandWidth-1:0] radicand;
    logic [pdi_pkg::CoordWidth-1:0]   first_x;
    logic [pdi_pkg::CoordWidth-1:0]   first_y;
    logic [pdi_pkg::CoordWidth-1:0]   second_x;
    logic [pdi_pkg::CoordWidth-1:0]   second_y;
  } request_t;

  // expected roots in item order, worked out when an item is taken
  class root_scoreboard;
    logic [pdi_pkg::RootWidth-1:0] expected_roots[$];
    int                            mismatches;

    function new();
      mismatches = 0;
    endfunction

    // restoring bit-pair root, one digit per pass, probe from the top pair down
    function logic [pdi_pkg::RootWidth-1:0] floor_root(
        logic [pdi_pkg::OperandWidth-1:0] operand);
      logic [pdi_pkg::OperandWidth+1:0] rest;
      logic [pdi_pkg::OperandWidth+1:0] partial;
      logic [pdi_pkg::OperandWidth+1:0] probe;
      rest    = {2'b00, operand};
      partial = '0;
      probe   = 34'h0_4000_0000;
      for (int k = 0; k < pdi_pkg::NumSteps; k++) begin
        if (rest >= partial + probe) begin
          rest    = rest - (partial + probe);
          partial = (partial >> 1) + probe;
        end else begin
          partial = partial >> 1;
        end
        probe = probe >> 2;
      end
      return partial[pdi_pkg::RootWidth-1:0];
    endfunction

    // squared euclidean distance, always fits in 32 bits for 15-bit coords
    function logic [pdi_pkg::OperandWidth-1:0] squared_distance(request_t req);
      logic [pdi_pkg::CoordWidth-1:0] dx;
      logic [pdi_pkg::CoordWidth-1:0] dy;
      dx = (req.first_x >= req.second_x) ? req.first_x - req.second_x
                                         : req.second_x - req.first_x;
      dy = (req.first_y >= req.second_y) ? req.first_y - req.second_y
                                         : req.second_y - req.first_y;
      return pdi_pkg::OperandWidth'(dx) * pdi_pkg::OperandWidth'(dx)
           + pdi_pkg::OperandWidth'(dy) * pdi_pkg::OperandWidth'(dy);
    endfunction

    function void note_request(request_t req);
      if (req.command == pdi_pkg::CMD_DISTANCE) begin
        expected_roots.push_back(floor_root(squared_distance(req)));
      end else begin
        expected_roots.push_back(floor_root(req.radicand));
      end
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_root(logic [pdi_pkg::RootWidth-1:0] got);
      logic [pdi_pkg::RootWidth-1:0] want;
      if (expected_roots.size() == 0) begin
        report($sformatf("root %0d with no item outstanding", got));
      end else begin
        want = expected_roots.pop_front();
        if (got !== want) begin
          report($sformatf("root_value got %0d want %0d", got, want));
        end
      end
    endtask
  endclass

  localparam int ClkPeriod    = 10;
  localparam int HoldCycles   = 300;   // long receiver back-off
  localparam int StallLimit   = 2000;  // cycles with no handshake before giving up
  localparam int DrainCycles  = 40;    // pipeline is 18 deep
  localparam int RandomItems  = 1830;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic                             in_command;
  logic [pdi_pkg::OperandWidth-1:0] in_radicand;
  logic [pdi_pkg::CoordWidth-1:0]   in_first_x;
  logic [pdi_pkg::CoordWidth-1:0]   in_first_y;
  logic [pdi_pkg::CoordWidth-1:0]   in_second_x;
  logic [pdi_pkg::CoordWidth-1:0]   in_second_y;
  logic                             out_valid;
  logic                             out_ready;
  logic [pdi_pkg::RootWidth-1:0]    out_root_value;

  root_scoreboard root_board;

  // idling controls for the stimulus and the result side, and the watchdog count
  bit tx_steady;
  bit rx_steady;
  bit rx_hold_req;
  int stall_cycles;

  point_distance_isqrt_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_radicand    (in_radicand),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_root_value (out_root_value)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #(ClkPeriod / 2) clk = ~clk;
    end
  end

  // offer one item and hold it until the block takes it
  task push_item(request_t req);
    in_valid    <= 1'b1;
    in_command  <= req.command;
    in_radicand <= req.radicand;
    in_first_x  <= req.first_x;
    in_first_y  <= req.first_y;
    in_second_x <= req.second_x;
    in_second_y <= req.second_y;
    do begin
      @(posedge clk);
    end while (!in_ready);
    root_board.note_request(req);
  endtask

  // each cycle idles with odds of 17 in 100, so gaps come out geometric
  task maybe_idle();
    while (!tx_steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // sender stops until the pipeline is empty
  task wait_for_drain();
    in_valid <= 1'b0;
    while (root_board.pending() != 0) @(posedge clk);
    // keeps the next valid rise off the step where it was lowered
    @(posedge clk);
  endtask

  function request_t make_request(pdi_pkg::command_t cmd,
                                  logic [pdi_pkg::OperandWidth-1:0] radicand,
                                  int ax, int ay, int bx, int by);
    request_t req;
    req.command  = cmd;
    req.radicand = radicand;
    req.first_x  = pdi_pkg::CoordWidth'(ax);
    req.first_y  = pdi_pkg::CoordWidth'(ay);
    req.second_x = pdi_pkg::CoordWidth'(bx);
    req.second_y = pdi_pkg::CoordWidth'(by);
    return req;
  endfunction

  // random coordinate: full range, edges, or close to a given point
  function logic [pdi_pkg::CoordWidth-1:0] random_coord(
      logic [pdi_pkg::CoordWidth-1:0] near);
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) begin
      return pdi_pkg::CoordWidth'($urandom);
    end else if (pick < 7) begin
      return $urandom_range(1) ? '1 : '0;
    end else begin
      return near + pdi_pkg::CoordWidth'($urandom_range(15)) - pdi_pkg::CoordWidth'(8);
    end
  endfunction

  // random operand: full width, variable width, or next to a perfect square
  function logic [pdi_pkg::OperandWidth-1:0] random_radicand();
    int                               pick;
    logic [pdi_pkg::OperandWidth-1:0] base;
    pick = $urandom_range(9);
    base = $urandom_range(65535);
    if (pick < 4) begin
      return $urandom;
    end else if (pick < 7) begin
      return $urandom >> $urandom_range(31);
    end else begin
      return base * base + pdi_pkg::OperandWidth'($urandom_range(2))
           - pdi_pkg::OperandWidth'(1);
    end
  endfunction

  function request_t random_request();
    request_t req;
    req.command  = $urandom_range(1) ? pdi_pkg::CMD_ROOT : pdi_pkg::CMD_DISTANCE;
    // unused fields get random content
    req.radicand = (req.command == pdi_pkg::CMD_ROOT) ? random_radicand() : $urandom;
    req.first_x  = pdi_pkg::CoordWidth'($urandom);
    req.first_y  = pdi_pkg::CoordWidth'($urandom);
    req.second_x = random_coord(req.first_x);
    req.second_y = random_coord(req.first_y);
    if (req.command == pdi_pkg::CMD_DISTANCE && $urandom_range(7) == 0) begin
      req.first_x = random_coord(req.second_x);
    end
    return req;
  endfunction

  // result side: random back-pressure, steady stretches, and one long hold
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_ready <= rx_steady || ($urandom_range(99) >= 17);
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      root_board.check_root(out_root_value);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("point_distance_isqrt_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    root_board   = new();
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    rx_hold_req  = 1'b0;
    stall_cycles = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_command  <= pdi_pkg::CMD_DISTANCE;
    in_radicand <= '0;
    in_first_x  <= '0;
    in_first_y  <= '0;
    in_second_x <= '0;
    in_second_y <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: coincident points, farthest corners, swapped order, single axis
    push_item(make_request(pdi_pkg::CMD_DISTANCE, 32'hDEAD_BEEF, 1234, 4321, 1234, 4321));
    maybe_idle();
    push_item(make_request(pdi_pkg::CMD_DISTANCE, '0, 0, 0, 32767, 32767));
    push_item(make_request(pdi_pkg::CMD_DISTANCE, '1, 32767, 32767, 0, 0));
    push_item(make_request(pdi_pkg::CMD_DISTANCE, '0, 32767, 0, 0, 32767));
    push_item(make_request(pdi_pkg::CMD_DISTANCE, '0, 0, 0, 3, 4));
    push_item(make_request(pdi_pkg::CMD_DISTANCE, '0, 7, 100, 7, 0));
    push_item(make_request(pdi_pkg::CMD_DISTANCE, '0, 500, 9, 0, 9));
    push_item(make_request(pdi_pkg::CMD_DISTANCE, '1, 1, 1, 0, 0));
    maybe_idle();
    // directed roots: zero, tiny values, square edges, top of range
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'd0, 32767, 32767, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'd1, 0, 0, 32767, 32767));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'd2, 0, 0, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'd3, 0, 0, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'd4, 0, 0, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'hFFFF_FFFF, 0, 0, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'hFFFE_0001, 0, 0, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'hFFFE_0000, 0, 0, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'h4000_0000, 0, 0, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'h3FFF_FFFF, 0, 0, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'h8000_0000, 0, 0, 0, 0));
    push_item(make_request(pdi_pkg::CMD_ROOT, 32'h0000_FFFF, 0, 0, 0, 0));

    // random with idling on both sides
    for (int n = 0; n < 600; n++) begin
      maybe_idle();
      push_item(random_request());
    end

    // long stretch with no idling at all
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int n = 0; n < 400; n++) begin
      push_item(random_request());
    end

    // receiver backs off while items keep coming, so the row fills and stalls
    rx_steady   = 1'b0;
    rx_hold_req = 1'b1;
    for (int n = 0; n < 60; n++) begin
      push_item(random_request());
    end
    tx_steady = 1'b0;
    wait_for_drain();

    // rest of the random items with idling again
    for (int n = 0; n < RandomItems - 1060; n++) begin
      maybe_idle();
      push_item(random_request());
    end

    in_valid <= 1'b0;
    while (root_board.pending() != 0) @(posedge clk);
    // catch any stray results after the last expected one
    repeat (DrainCycles) @(posedge clk);

    if (root_board.mismatches == 0) begin
      $display("point_distance_isqrt_core verification clean");
    end else begin
      $display("point_distance_isqrt_core verification failed");
    end
    $finish;
  end

endmodule
